>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg
// Types and constants shared by the text console blocks.
// ----------------------------------------------------------------------------
package tcm_pkg;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_MOVE = 2'd1,
        OP_READ = 2'd2
    } tcm_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_WIPE,
        ST_IDLE,
        ST_RD_WAIT,
        ST_MS_OLD,
        ST_MS_NEW,
        ST_DONE
    } tcm_state_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_DEFAULT = 8'h07;
    localparam logic [7:0] ATTR_HILITE  = 8'h70;

    typedef struct packed {
        logic       attr_we;
        logic       char_we;
        logic [7:0] attr_wdata;
        logic [7:0] char_wdata;
    } tcm_mem_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [10:0] text_cursor;
        logic [6:0]  mouse_col;
        logic [4:0]  mouse_row;
    } tcm_res_t;

    function automatic logic [7:0] swap_nibbles(input logic [7:0] attr);
        swap_nibbles = {attr[3:0], attr[7:4]};
    endfunction

endpackage

>>> rtl/tcm_screen_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_screen_mem
// Screen storage: attribute and character planes, one write port and one
// registered read port each.
// ----------------------------------------------------------------------------
module tcm_screen_mem #(
    parameter int CELLS = 2000,
    parameter int AW    = 11
) (
    input  logic                 aclk,
    input  tcm_pkg::tcm_mem_req_t req,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr,
    output logic [7:0]           rd_attr,
    output logic [7:0]           rd_char
);
    import tcm_pkg::*;

    logic [7:0] attr_mem [CELLS];
    logic [7:0] char_mem [CELLS];
    logic [7:0] rd_attr_reg;
    logic [7:0] rd_char_reg;

    always_ff @(posedge aclk) begin
        if (req.attr_we) begin
            attr_mem[wr_addr] <= req.attr_wdata;
        end
        rd_attr_reg <= attr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (req.char_we) begin
            char_mem[wr_addr] <= req.char_wdata;
        end
        rd_char_reg <= char_mem[rd_addr];
    end

    assign rd_attr = rd_attr_reg;
    assign rd_char = rd_char_reg;

endmodule

>>> rtl/tcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_ctrl
// Sequencer: cursor and pointer state, screen sweeps and the
// read-modify-write steps on the screen memory.
// ----------------------------------------------------------------------------
module tcm_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CELLS   = 2000,
    parameter int AW      = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [7:0]            s_char_code,
    input  logic signed [7:0]     s_move_dx,
    input  logic signed [7:0]     s_move_dy,
    input  logic [10:0]           s_cell_index,
    output tcm_pkg::tcm_mem_req_t mem_req,
    output logic [AW-1:0]         wr_addr,
    output logic [AW-1:0]         rd_addr,
    input  logic [7:0]            rd_attr,
    input  logic [7:0]            rd_char,
    output logic                  res_valid,
    input  logic                  res_ready,
    output tcm_pkg::tcm_res_t     res
);
    import tcm_pkg::*;

    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int XW     = ((AW > 11) ? AW : 11) + 1;
    localparam int CENTER = (ROWS / 2) * COLUMNS + (COLUMNS / 2);
    localparam logic signed [9:0] COL_MAX = 10'(COLUMNS - 1);
    localparam logic signed [9:0] ROW_MAX = 10'(ROWS - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(COLUMNS) + AW'(c);
    endfunction

    tcm_state_t    state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [CW-1:0] tcol_reg, tcol_next;
    logic [RW-1:0] trow_reg, trow_next;
    logic [CW-1:0] pcol_reg, pcol_next;
    logic [RW-1:0] prow_reg, prow_next;
    logic [CW-1:0] pend_col_reg, pend_col_next;
    logic [RW-1:0] pend_row_reg, pend_row_next;
    logic [15:0]   rdata_reg, rdata_next;
    logic          in_range_reg, in_range_next;

    logic          accept;
    logic          sweep_last;
    logic          same_cell;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] ptr_addr;
    logic [AW-1:0] pend_addr;
    logic [XW-1:0] cell_ext;
    logic          idx_in_range;
    logic [AW-1:0] idx_addr;

    // put-character datapath
    logic          is_nul, is_lf, is_bs;
    logic [CW-1:0] bs_col;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [CW-1:0] put_col;
    logic [RW:0]   put_row;
    logic          put_overflow;

    // mouse datapath
    logic signed [9:0] c_wide;
    logic signed [9:0] r_wide;
    logic [CW-1:0]     c_clamp;
    logic [RW-1:0]     r_clamp;

    assign accept       = s_valid && s_ready;
    assign sweep_last   = (sweep_reg == AW'(CELLS - 1));
    assign same_cell    = (pend_col_reg == pcol_reg) && (pend_row_reg == prow_reg);
    assign cur_addr     = cell_addr(trow_reg, tcol_reg);
    assign ptr_addr     = cell_addr(prow_reg, pcol_reg);
    assign pend_addr    = cell_addr(pend_row_reg, pend_col_reg);
    assign cell_ext     = XW'(s_cell_index);
    assign idx_in_range = (cell_ext < XW'(CELLS));
    assign idx_addr     = cell_ext[AW-1:0];

    assign is_nul  = (s_char_code == CH_NUL);
    assign is_lf   = (s_char_code == CH_LF);
    assign is_bs   = (s_char_code == CH_BS);
    assign bs_col  = (tcol_reg != '0) ? (tcol_reg - 1'b1) : tcol_reg;
    assign col_inc = {1'b0, tcol_reg} + 1'b1;
    assign row_inc = {1'b0, trow_reg} + 1'b1;

    always_comb begin
        put_col = tcol_reg;
        put_row = {1'b0, trow_reg};
        if (is_nul) begin
            put_col = tcol_reg;
        end else if (is_lf) begin
            put_col = '0;
            put_row = row_inc;
        end else if (is_bs) begin
            put_col = bs_col;
        end else if (col_inc == (CW+1)'(COLUMNS)) begin
            put_col = '0;
            put_row = row_inc;
        end else begin
            put_col = col_inc[CW-1:0];
        end
    end

    assign put_overflow = (put_row == (RW+1)'(ROWS));

    assign c_wide = $signed({3'b000, 7'(pcol_reg)})
                  + $signed({{2{s_move_dx[7]}}, s_move_dx});
    assign r_wide = $signed({5'b00000, 5'(prow_reg)})
                  - $signed({{2{s_move_dy[7]}}, s_move_dy});

    always_comb begin
        if (c_wide < 10'sd0) begin
            c_clamp = '0;
        end else if (c_wide > COL_MAX) begin
            c_clamp = CW'(COLUMNS - 1);
        end else begin
            c_clamp = c_wide[CW-1:0];
        end
        if (r_wide < 10'sd0) begin
            r_clamp = '0;
        end else if (r_wide > ROW_MAX) begin
            r_clamp = RW'(ROWS - 1);
        end else begin
            r_clamp = r_wide[RW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE: begin
                if (sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_opcode)
                        OP_PUT:  state_next = put_overflow ? ST_WIPE : ST_DONE;
                        OP_MOVE: state_next = ST_MS_OLD;
                        OP_READ: state_next = ST_RD_WAIT;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_MS_OLD:  state_next = same_cell ? ST_DONE : ST_MS_NEW;
            ST_MS_NEW:  state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    // outputs: handshake and memory port control
    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        mem_req   = '0;
        wr_addr   = '0;
        rd_addr   = '0;
        case (state_reg)
            ST_INIT: begin
                mem_req.attr_we    = 1'b1;
                mem_req.char_we    = 1'b1;
                mem_req.attr_wdata = (sweep_reg == AW'(CENTER)) ? ATTR_HILITE : ATTR_DEFAULT;
                mem_req.char_wdata = CH_SPACE;
                wr_addr            = sweep_reg;
            end
            ST_WIPE: begin
                mem_req.char_we    = 1'b1;
                mem_req.char_wdata = CH_SPACE;
                wr_addr            = sweep_reg;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_opcode)
                        OP_PUT: begin
                            if (is_bs) begin
                                mem_req.char_we    = 1'b1;
                                mem_req.char_wdata = CH_SPACE;
                                wr_addr            = cell_addr(trow_reg, bs_col);
                            end else if (!is_nul && !is_lf) begin
                                mem_req.char_we    = 1'b1;
                                mem_req.char_wdata = s_char_code;
                                wr_addr            = cur_addr;
                            end
                        end
                        OP_MOVE: rd_addr = ptr_addr;
                        OP_READ: rd_addr = idx_in_range ? idx_addr : '0;
                        default: rd_addr = '0;
                    endcase
                end
            end
            ST_MS_OLD: begin
                // write-back of the old cell goes to a different address than
                // the read of the new one; equal cells skip both swaps
                rd_addr = pend_addr;
                if (!same_cell) begin
                    mem_req.attr_we    = 1'b1;
                    mem_req.attr_wdata = swap_nibbles(rd_attr);
                    wr_addr            = ptr_addr;
                end
            end
            ST_MS_NEW: begin
                mem_req.attr_we    = 1'b1;
                mem_req.attr_wdata = swap_nibbles(rd_attr);
                wr_addr            = ptr_addr;
            end
            ST_DONE: res_valid = 1'b1;
            default: res_valid = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        sweep_next    = sweep_reg;
        tcol_next     = tcol_reg;
        trow_next     = trow_reg;
        pcol_next     = pcol_reg;
        prow_next     = prow_reg;
        pend_col_next = pend_col_reg;
        pend_row_next = pend_row_reg;
        rdata_next    = rdata_reg;
        in_range_next = in_range_reg;
        case (state_reg)
            ST_INIT, ST_WIPE: begin
                sweep_next = sweep_last ? '0 : (sweep_reg + 1'b1);
            end
            ST_IDLE: begin
                if (accept) begin
                    rdata_next = '0;
                    case (s_opcode)
                        OP_PUT: begin
                            if (put_overflow) begin
                                tcol_next = '0;
                                trow_next = '0;
                            end else begin
                                tcol_next = put_col;
                                trow_next = put_row[RW-1:0];
                            end
                        end
                        OP_MOVE: begin
                            pend_col_next = c_clamp;
                            pend_row_next = r_clamp;
                        end
                        OP_READ: in_range_next = idx_in_range;
                        default: rdata_next = '0;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                rdata_next = in_range_reg ? {rd_attr, rd_char} : 16'h0000;
            end
            ST_MS_OLD: begin
                pcol_next = pend_col_reg;
                prow_next = pend_row_reg;
            end
            default: sweep_next = sweep_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            tcol_reg  <= '0;
            trow_reg  <= '0;
            pcol_reg  <= CW'(COLUMNS / 2);
            prow_reg  <= RW'(ROWS / 2);
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            tcol_reg  <= tcol_next;
            trow_reg  <= trow_next;
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_col_reg <= pend_col_next;
        pend_row_reg <= pend_row_next;
        rdata_reg    <= rdata_next;
        in_range_reg <= in_range_next;
    end

    assign res.read_data   = rdata_reg;
    assign res.text_cursor = 11'(cur_addr);
    assign res.mouse_col   = 7'(pcol_reg);
    assign res.mouse_row   = 5'(prow_reg);

endmodule

>>> rtl/text_console_with_mouse_highlight_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_with_mouse_highlight_top
// Text screen of attribute/character cells with a text cursor and a
// highlighted mouse cell, held in a dual-plane screen memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | opcode, char_code, move_dx/dy, cell_index
//  m_      | out       | m_valid / m_ready  | read_data, text_cursor, mouse_col/row
//
//  A put character goes from idle straight to the final state, a read through a
//  read-wait state, a mouse move through an old-cell state and, unless the cell is
//  the same, a new-cell state; the registered memory read and the old/new attribute
//  swap set these states. A put that runs past the last row adds a wipe of all
//  COLUMNS*ROWS cells (2000); after reset, s_ready is low during the screen init.
//  A stalled m_ side holds one result in the output register while the next
//  transaction is worked on; that one waits in its final state.
// ----------------------------------------------------------------------------
module text_console_with_mouse_highlight_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [7:0]        s_char_code,
    input  logic signed [7:0] s_move_dx,
    input  logic signed [7:0] s_move_dy,
    input  logic [10:0]       s_cell_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_read_data,
    output logic [10:0]       m_text_cursor,
    output logic [6:0]        m_mouse_col,
    output logic [4:0]        m_mouse_row
);
    import tcm_pkg::*;
    `include "assert_macros.svh"

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    tcm_mem_req_t  mem_req;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_attr;
    logic [7:0]    rd_char;
    logic          res_valid;
    logic          res_ready;
    tcm_res_t      res;

    logic     out_valid_reg, out_valid_next;
    tcm_res_t out_res_reg, out_res_next;

    // Screen planes: attribute byte and character byte kept apart, so a
    // character write never needs a read and a wipe touches characters only.
    tcm_screen_mem #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_attr (rd_attr),
        .rd_char (rd_char)
    );

    tcm_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_char_code  (s_char_code),
        .s_move_dx    (s_move_dx),
        .s_move_dy    (s_move_dy),
        .s_cell_index (s_cell_index),
        .mem_req      (mem_req),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .rd_attr      (rd_attr),
        .rd_char      (rd_char),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Output register: take a new result when empty or being drained.
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready) begin
            // load the finished transaction
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_ready) begin
            // drop the delivered result
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_read_data   = out_res_reg.read_data;
    assign m_text_cursor = out_res_reg.text_cursor;
    assign m_mouse_col   = out_res_reg.mouse_col;
    assign m_mouse_row   = out_res_reg.mouse_row;

    // One transaction at a time: input is closed while a result is offered.
    `ASSERT_IMPLIES(a_no_input_while_done, aclk, aresetn, res_valid, !s_ready)
    // An accepted transaction always leaves the idle state.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Pointer clamping keeps the highlight on the screen.
    `ASSERT_IMPLIES(a_mouse_on_screen, aclk, aresetn, m_valid,
        (32'(m_mouse_col) < COLUMNS) && (32'(m_mouse_row) < ROWS))

endmodule

>>> tb/console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_checker
// Watches both channels of the text console, keeps its own copy of the
// screen, the text cursor and the mouse highlight, and compares every result
// transaction field by field with the predicted status.
// ----------------------------------------------------------------------------
module console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_move_dx,
    input  logic [7:0]  s_move_dy,
    input  logic [10:0] s_cell_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_read_data,
    input  logic [10:0] m_text_cursor,
    input  logic [6:0]  m_mouse_col,
    input  logic [4:0]  m_mouse_row,
    output int          fail_count,
    output int          pending_count
);
    import tcm_pkg::*;

    localparam int CELLS      = COLUMNS * ROWS;

    logic [15:0] screen_mem [CELLS];
    int          cur_col;
    int          cur_row;
    int          ptr_col;
    int          ptr_row;
    tcm_res_t    predicted_status [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] result mismatch on %s: got 0x%0h, want 0x%0h",
                 $time, what, got, want);
    endtask

    // Exchange the foreground and background nibbles of one attribute.
    function automatic void flip_highlight(input int col, input int row);
        int          idx;
        logic [15:0] w;
        idx = row * COLUMNS + col;
        w   = screen_mem[idx];
        screen_mem[idx] = {w[11:8], w[15:12], w[7:0]};
    endfunction

    function automatic void reset_console();
        for (int i = 0; i < CELLS; i++) begin
            screen_mem[i] = {ATTR_DEFAULT, CH_SPACE};
        end
        cur_col = 0;
        cur_row = 0;
        ptr_col = COLUMNS / 2;
        ptr_row = ROWS / 2;
        flip_highlight(ptr_col, ptr_row);
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        if (ch == CH_NUL) begin
            return;
        end
        if (ch == CH_LF) begin
            cur_row++;
            cur_col = 0;
        end else if (ch == CH_BS) begin
            if (cur_col > 0) begin
                cur_col--;
            end
            screen_mem[cur_row * COLUMNS + cur_col][7:0] = CH_SPACE;
        end else begin
            screen_mem[cur_row * COLUMNS + cur_col][7:0] = ch;
            cur_col++;
        end
        if (cur_col >= COLUMNS) begin
            cur_row++;
            cur_col = 0;
        end
        // Running off the last row blanks every character, attributes stay.
        if (cur_row >= ROWS) begin
            for (int i = 0; i < CELLS; i++) begin
                screen_mem[i][7:0] = CH_SPACE;
            end
            cur_col = 0;
            cur_row = 0;
        end
    endfunction

    function automatic void move_pointer(input logic signed [7:0] dx,
                                         input logic signed [7:0] dy);
        int c;
        int r;
        flip_highlight(ptr_col, ptr_row);
        c = ptr_col + int'(dx);
        r = ptr_row - int'(dy);
        if (c >= COLUMNS) c = COLUMNS - 1;
        if (c < 0)        c = 0;
        if (r >= ROWS)    r = ROWS - 1;
        if (r < 0)        r = 0;
        ptr_col = c;
        ptr_row = r;
        flip_highlight(ptr_col, ptr_row);
    endfunction

    always @(posedge aclk) begin : watch_channels
        tcm_res_t want;
        tcm_res_t next_status;
        if (!aresetn) begin
            reset_console();
            predicted_status.delete();
            pending_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_status.size() == 0) begin
                    report_mismatch("result with nothing pending", m_read_data, 0);
                end else begin
                    want = predicted_status.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_text_cursor !== want.text_cursor)
                        report_mismatch("text_cursor", m_text_cursor, want.text_cursor);
                    if (m_mouse_col !== want.mouse_col)
                        report_mismatch("mouse_col", m_mouse_col, want.mouse_col);
                    if (m_mouse_row !== want.mouse_row)
                        report_mismatch("mouse_row", m_mouse_row, want.mouse_row);
                end
            end
            if (s_valid && s_ready) begin
                next_status.read_data = '0;
                case (s_opcode)
                    OP_PUT:  put_char(s_char_code);
                    OP_MOVE: move_pointer(s_move_dx, s_move_dy);
                    OP_READ: begin
                        if (s_cell_index < CELLS) begin
                            next_status.read_data = screen_mem[s_cell_index];
                        end
                    end
                    default: ;
                endcase
                next_status.text_cursor = 11'(cur_row * COLUMNS + cur_col);
                next_status.mouse_col   = 7'(ptr_col);
                next_status.mouse_row   = 5'(ptr_row);
                predicted_status.push_back(next_status);
            end
            pending_count = predicted_status.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the text console with directed and random transactions under random
// idling on both channels; the console checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import tcm_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ITEM_COUNT  = 1400;
    localparam int IDLE_PCT    = 32;
    localparam int CALM_FIRST  = 500;     // first transaction of the no-idle stretch
    localparam int CALM_LAST   = 750;
    localparam int DRAIN_WAIT  = 50;
    localparam int CYCLE_LIMIT = 500000;

    // Opcode value that the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode     = OP_PUT;
    logic [7:0]  s_char_code  = 8'h00;
    logic [7:0]  s_move_dx    = 8'h00;
    logic [7:0]  s_move_dy    = 8'h00;
    logic [10:0] s_cell_index = 11'd0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [15:0] m_read_data;
    logic [10:0] m_text_cursor;
    logic [6:0]  m_mouse_col;
    logic [4:0]  m_mouse_row;

    int fail_count;
    int pending_count;
    int items_sent = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    text_console_with_mouse_highlight_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_char_code   (s_char_code),
        .s_move_dx     (s_move_dx),
        .s_move_dy     (s_move_dy),
        .s_cell_index  (s_cell_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_text_cursor (m_text_cursor),
        .m_mouse_col   (m_mouse_col),
        .m_mouse_row   (m_mouse_row)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_char_code   (s_char_code),
        .s_move_dx     (s_move_dx),
        .s_move_dy     (s_move_dy),
        .s_cell_index  (s_cell_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_text_cursor (m_text_cursor),
        .m_mouse_col   (m_mouse_col),
        .m_mouse_row   (m_mouse_row),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Result side: stall at random, except during the calm stretch.
    always @(negedge aclk) begin
        m_ready <= aresetn && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: give up if the run hangs anywhere.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted. Called and returns at a
    // falling edge; random idle cycles go in front unless the stretch is calm.
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [7:0] dx, input logic [7:0] dy,
                             input logic [10:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_char_code  <= ch;
        s_move_dx    <= dx;
        s_move_dy    <= dy;
        s_cell_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Unused fields still carry random values so every bit toggles.
    task automatic send_put(input logic [7:0] ch);
        send_item(OP_PUT, ch, 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    task automatic send_move(input logic [7:0] dx, input logic [7:0] dy);
        send_item(OP_MOVE, 8'($urandom), dx, dy, 11'($urandom));
    endtask

    task automatic send_read(input logic [10:0] idx);
        send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
    endtask

    // Mostly ordinary bytes, with control characters weighted up.
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return CH_LF;
        if (roll < 25) return CH_BS;
        if (roll < 30) return CH_NUL;
        return 8'($urandom_range(255));
    endfunction

    initial begin : stimulus
        int roll;
        logic [7:0] dx;
        logic [7:0] dy;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset highlight, plain and high bytes, no-op, backspace
        // stopping at column 0, newline, mouse clamps on every side, the
        // same-cell move, out-of-range reads and the unused opcode.
        send_read(11'(CELLS / 2));
        send_read(11'd0);
        send_put(8'h41);
        send_put(8'hFF);
        send_put(8'h80);
        send_put(CH_NUL);
        send_read(11'd1);
        repeat (4) send_put(CH_BS);
        send_put(CH_LF);
        send_move(8'h00, 8'h00);
        send_move(8'h7F, 8'h80);
        send_move(8'h80, 8'h7F);
        send_read(11'd0);
        send_read(11'(CELLS - 1));
        send_read(11'(CELLS));
        send_read(11'h7FF);
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 11'h7FF);

        // Random part with a calm stretch in the middle.
        while (items_sent < ITEM_COUNT) begin
            calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
            roll = $urandom_range(99);
            if (roll < 2) begin
                // run the cursor off the last row to force a screen wipe
                repeat (ROWS + 1) send_put(CH_LF);
            end else if (roll < 3) begin
                // a line of text long enough to wrap
                repeat (COLUMNS + 2) send_put(8'($urandom_range(126, 32)));
            end else if (roll < 48) begin
                send_put(pick_char());
            end else if (roll < 72) begin
                if ($urandom_range(9) < 7) begin
                    dx = 8'($urandom_range(8)) - 8'd4;
                    dy = 8'($urandom_range(8)) - 8'd4;
                end else begin
                    dx = 8'($urandom);
                    dy = 8'($urandom);
                end
                send_move(dx, dy);
            end else if (roll < 97) begin
                if ($urandom_range(9) == 0)
                    send_read(11'($urandom));
                else
                    send_read(11'($urandom_range(CELLS - 1)));
            end else begin
                send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                          11'($urandom));
            end
        end
        calm = 1'b0;

        // Drop valid, drain the results, then allow a few more cycles for
        // anything stray to show up.
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
